[rtl/tdps_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdps_pkg
// Types and constants shared by the two-channel pwm duty sequencer.
// ----------------------------------------------------------------------------
package tdps_pkg;

  localparam int DUTY_W    = 16;
  localparam int IN_DUTY_W = 17;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [IN_DUTY_W-1:0] DUTY_ONE   = 17'd32768;
  localparam logic [CFG_W-1:0]     WRAP_RESET = 16'd12499;
  localparam logic [CFG_W-1:0]     STEP_RESET = 16'd1;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_MS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_WRAP = 1'b1;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_BEGIN = 2'd1,
    KIND_ROW   = 2'd2,
    KIND_END   = 2'd3
  } kind_t;

  // per-word status carried from the control stage to the level stage
  typedef struct packed {
    logic play;
    logic armed;
    logic nz_a;
    logic nz_b;
  } stat_t;

endpackage

`default_nettype wire

[rtl/tdps_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdps_in_if / tdps_out_if
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface tdps_in_if;
  import tdps_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [1:0]                  kind;
  logic                        trigger;
  logic signed [IN_DUTY_W-1:0] duty_a;
  logic signed [IN_DUTY_W-1:0] duty_b;
  logic                        b_present;

  modport source (output valid, kind, trigger, duty_a, duty_b, b_present, input ready);
  modport sink   (input valid, kind, trigger, duty_a, duty_b, b_present, output ready);
endinterface

interface tdps_out_if;
  import tdps_pkg::*;

  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] level_a;
  logic [DUTY_W-1:0] level_b;
  logic              playing;
  logic              armed;

  modport source (output valid, level_a, level_b, playing, armed, input ready);
  modport sink   (input valid, level_a, level_b, playing, armed, output ready);
endinterface

`default_nettype wire

[rtl/tdps_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdps_ram
// Generic single-write, single-read ram with registered read data.
// ----------------------------------------------------------------------------
module tdps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic                                     re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/tdps_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdps_ctrl
// Sequencer state: table loading, trigger start/stop and step timing.
// Drives duty store writes and the read address for the state after a word.
// ----------------------------------------------------------------------------
module tdps_ctrl #(
  parameter int MAX_STEPS = 64,
  parameter int ADDR_W    = 6
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   fire,
  input  wire logic [1:0]                             kind,
  input  wire logic                                   trigger,
  input  wire logic [tdps_pkg::IN_DUTY_W-1:0]          duty_a,
  input  wire logic [tdps_pkg::IN_DUTY_W-1:0]          duty_b,
  input  wire logic                                   b_present,
  input  wire logic [tdps_pkg::CFG_W-1:0]              step_ms,
  output logic                                        we_a,
  output logic                                        we_b,
  output logic      [ADDR_W-1:0]                      waddr_a,
  output logic      [ADDR_W-1:0]                      waddr_b,
  output logic      [ADDR_W-1:0]                      raddr_a,
  output logic      [ADDR_W-1:0]                      raddr_b,
  output tdps_pkg::stat_t                             stat_nxt
);
  import tdps_pkg::*;

  localparam int CNT_W = $clog2(MAX_STEPS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_STEPS);

  logic [CNT_W-1:0] count_a_r, count_a_nxt;
  logic [CNT_W-1:0] count_b_r, count_b_nxt;
  logic [CNT_W-1:0] loop_r, loop_nxt;
  logic [CNT_W-1:0] step_r, step_nxt;
  logic [CFG_W-1:0] ms_r, ms_nxt;
  logic             load_r, load_nxt;
  logic             enabled_r, enabled_nxt;
  logic             running_r, running_nxt;

  logic [CFG_W-1:0] period;
  logic [CFG_W:0]   ms_inc;
  logic [CNT_W:0]   step_inc;
  logic             ok_a, ok_b;
  logic [CNT_W-1:0] idx_a, idx_b;

  assign period   = (step_ms == '0) ? STEP_RESET : step_ms;
  assign ms_inc   = {1'b0, ms_r} + {{CFG_W{1'b0}}, 1'b1};
  assign step_inc = {1'b0, step_r} + {{CNT_W{1'b0}}, 1'b1};
  assign ok_a     = load_r && (count_a_r < MAX_CNT) && (duty_a <= DUTY_ONE);
  assign ok_b     = load_r && b_present && (count_b_r < MAX_CNT) && (duty_b <= DUTY_ONE);

  always_comb begin
    count_a_nxt = count_a_r;
    count_b_nxt = count_b_r;
    loop_nxt    = loop_r;
    step_nxt    = step_r;
    ms_nxt      = ms_r;
    load_nxt    = load_r;
    enabled_nxt = enabled_r;
    running_nxt = running_r;
    we_a        = 1'b0;
    we_b        = 1'b0;
    if (fire) begin
      unique case (kind_t'(kind))
        KIND_TICK: begin
          if (trigger && !running_r && enabled_r) begin
            running_nxt = 1'b1;
            step_nxt    = '0;
            ms_nxt      = '0;
          end else if (!trigger && running_r) begin
            running_nxt = 1'b0;
          end else if (running_r && enabled_r) begin
            if (ms_inc >= {1'b0, period}) begin
              ms_nxt   = '0;
              step_nxt = (step_inc >= {1'b0, loop_r}) ? '0 : step_inc[CNT_W-1:0];
            end else begin
              ms_nxt = ms_inc[CFG_W-1:0];
            end
          end
        end
        KIND_BEGIN: begin
          count_a_nxt = '0;
          count_b_nxt = '0;
          load_nxt    = 1'b1;
          enabled_nxt = 1'b0;
          running_nxt = 1'b0;
        end
        KIND_ROW: begin
          we_a = ok_a;
          we_b = ok_b;
          if (ok_a) begin
            count_a_nxt = count_a_r + {{(CNT_W-1){1'b0}}, 1'b1};
          end
          if (ok_b) begin
            count_b_nxt = count_b_r + {{(CNT_W-1){1'b0}}, 1'b1};
          end
        end
        KIND_END: begin
          if (load_r) begin
            load_nxt    = 1'b0;
            loop_nxt    = (count_a_r > count_b_r) ? count_a_r : count_b_r;
            enabled_nxt = (count_a_r != '0) || (count_b_r != '0);
            step_nxt    = '0;
            ms_nxt      = '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign waddr_a = count_a_r[ADDR_W-1:0];
  assign waddr_b = count_b_r[ADDR_W-1:0];

  // a channel past its end holds its last entry
  assign idx_a   = (step_nxt < count_a_nxt) ? step_nxt : count_a_nxt - {{(CNT_W-1){1'b0}}, 1'b1};
  assign idx_b   = (step_nxt < count_b_nxt) ? step_nxt : count_b_nxt - {{(CNT_W-1){1'b0}}, 1'b1};
  assign raddr_a = idx_a[ADDR_W-1:0];
  assign raddr_b = idx_b[ADDR_W-1:0];

  assign stat_nxt.play  = running_nxt && enabled_nxt;
  assign stat_nxt.armed = enabled_nxt;
  assign stat_nxt.nz_a  = count_a_nxt != '0;
  assign stat_nxt.nz_b  = count_b_nxt != '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_a_r <= '0;
      count_b_r <= '0;
      loop_r    <= '0;
      step_r    <= '0;
      ms_r      <= '0;
      load_r    <= 1'b0;
      enabled_r <= 1'b0;
      running_r <= 1'b0;
    end else begin
      count_a_r <= count_a_nxt;
      count_b_r <= count_b_nxt;
      loop_r    <= loop_nxt;
      step_r    <= step_nxt;
      ms_r      <= ms_nxt;
      load_r    <= load_nxt;
      enabled_r <= enabled_nxt;
      running_r <= running_nxt;
    end
  end

  a_run_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
    running_r |-> enabled_r)
    else $error("running without a loaded sequence");

  a_step_in_loop: assert property (@(posedge clk) disable iff (!rst_n)
    running_r |-> (step_r < loop_r))
    else $error("step position outside loop length");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_a_r <= MAX_CNT) && (count_b_r <= MAX_CNT))
    else $error("table count beyond capacity");

  a_no_write_outside_load: assert property (@(posedge clk) disable iff (!rst_n)
    (we_a || we_b) |-> (load_r && !running_r))
    else $error("duty store written outside load mode");

endmodule

`default_nettype wire

[rtl/tdps_level.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdps_level
// Scales the two looked-up duties by the pwm wrap and holds the result word.
// ----------------------------------------------------------------------------
module tdps_level (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        s1_valid,
  input  wire tdps_pkg::stat_t             s1_stat,
  input  wire logic [tdps_pkg::DUTY_W-1:0] duty_a,
  input  wire logic [tdps_pkg::DUTY_W-1:0] duty_b,
  input  wire logic [tdps_pkg::CFG_W-1:0]  pwm_wrap,
  output logic                             adv,
  tdps_out_if.source                       out_ch
);
  import tdps_pkg::*;

  localparam int PROD_W = DUTY_W + CFG_W;

  logic              out_valid_r;
  logic [DUTY_W-1:0] level_a_r, level_b_r;
  logic              playing_r, armed_r;
  logic [PROD_W-1:0] prod_a, prod_b;

  assign adv    = !out_valid_r || out_ch.ready;
  assign prod_a = duty_a * pwm_wrap;
  assign prod_b = duty_b * pwm_wrap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid;
    end
  end

  // level = duty * wrap >> 15, low 16 bits; zero unless playing and the channel is nonempty
  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      level_a_r <= (s1_stat.play && s1_stat.nz_a) ? prod_a[DUTY_W+14:15] : '0;
      level_b_r <= (s1_stat.play && s1_stat.nz_b) ? prod_b[DUTY_W+14:15] : '0;
      playing_r <= s1_stat.play;
      armed_r   <= s1_stat.armed;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.level_a = level_a_r;
  assign out_ch.level_b = level_b_r;
  assign out_ch.playing = playing_r;
  assign out_ch.armed   = armed_r;

endmodule

`default_nettype wire

[rtl/two_channel_pwm_duty_sequencer_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_channel_pwm_duty_sequencer_core
// Two-channel pwm duty sequencer: table load, trigger playback, level scaling.
// ----------------------------------------------------------------------------
// Every input word (tick, begin load, append row, end load) gives exactly one
// result word via the stage-one and output registers; a new word can be taken
// every cycle unless the output stalls. Stage one updates the sequencer state
// and reads both duty tables (one registered read port each); the output stage
// multiplies the duties by pwm_wrap. The tables need no clearing after reset.
// Write step_ms and pwm_wrap only while no word is in flight.
module two_channel_pwm_duty_sequencer_core #(
  parameter int MAX_STEPS = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  tdps_in_if.sink                              in_ch,
  tdps_out_if.source                           out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [tdps_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [tdps_pkg::CFG_W-1:0]      cfg_wdata
);
  import tdps_pkg::*;

  localparam int ADDR_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

  logic [CFG_W-1:0]  step_ms_r, pwm_wrap_r;
  logic              s1_valid_r;
  stat_t             s1_stat_r, stat_nxt;
  logic              adv, in_fire;
  logic              we_a, we_b;
  logic [ADDR_W-1:0] waddr_a, waddr_b, raddr_a, raddr_b;
  logic [DUTY_W-1:0] rdata_a, rdata_b;

  assign in_ch.ready = !s1_valid_r || adv;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_ms_r  <= STEP_RESET;
      pwm_wrap_r <= WRAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_STEP_MS:  step_ms_r  <= cfg_wdata;
        REG_PWM_WRAP: pwm_wrap_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tdps_ctrl #(
    .MAX_STEPS (MAX_STEPS),
    .ADDR_W    (ADDR_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (in_fire),
    .kind      (in_ch.kind),
    .trigger   (in_ch.trigger),
    .duty_a    (in_ch.duty_a),
    .duty_b    (in_ch.duty_b),
    .b_present (in_ch.b_present),
    .step_ms   (step_ms_r),
    .we_a      (we_a),
    .we_b      (we_b),
    .waddr_a   (waddr_a),
    .waddr_b   (waddr_b),
    .raddr_a   (raddr_a),
    .raddr_b   (raddr_b),
    .stat_nxt  (stat_nxt)
  );

  tdps_ram #(.WIDTH(DUTY_W), .DEPTH(MAX_STEPS)) u_store_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr_a),
    .wdata (in_ch.duty_a[DUTY_W-1:0]),
    .re    (in_fire),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  tdps_ram #(.WIDTH(DUTY_W), .DEPTH(MAX_STEPS)) u_store_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr_b),
    .wdata (in_ch.duty_b[DUTY_W-1:0]),
    .re    (in_fire),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  // stage one holds the word status while the table read completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_stat_r <= stat_nxt;
    end
  end

  tdps_level u_level (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid_r),
    .s1_stat  (s1_stat_r),
    .duty_a   (rdata_a),
    .duty_b   (rdata_b),
    .pwm_wrap (pwm_wrap_r),
    .adv      (adv),
    .out_ch   (out_ch)
  );

  a_fire_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_valid_r)
    else $error("accepted word lost before stage one");

  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && adv) |=> out_ch.valid)
    else $error("stage one word lost before output");

  a_play_needs_armed: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (!out_ch.playing || out_ch.armed))
    else $error("playing reported without armed");

  a_stopped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.playing) |-> (out_ch.level_a == '0 && out_ch.level_b == '0))
    else $error("nonzero level while stopped");

endmodule

`default_nettype wire

[dv/two_channel_pwm_duty_sequencer_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_channel_pwm_duty_sequencer_core_tb
// Sends load, append and tick words to the duty sequencer and keeps its own
// copy of the duty tables and playback state. Each result word is checked in
// order against that copy or a directed expectation, across several step_ms /
// pwm_wrap settings, with and without random stalls on both channels.
// ----------------------------------------------------------------------------
module two_channel_pwm_duty_sequencer_core_tb;
  import tdps_pkg::*;

  localparam int STEPS      = 64;
  localparam int N_DIRECTED = 28;
  localparam int N_PHASES   = 6;

  typedef struct packed {
    kind_t                kind;
    logic                 trigger;
    logic [IN_DUTY_W-1:0] duty_a;
    logic [IN_DUTY_W-1:0] duty_b;
    logic                 b_present;
  } word_t;

  typedef struct packed {
    logic [DUTY_W-1:0] level_a;
    logic [DUTY_W-1:0] level_b;
    logic              playing;
    logic              armed;
  } levels_t;

  typedef struct packed {
    word_t   w;
    logic    typed;
    levels_t want;
  } row_t;

  // kind, trigger, duty_a, duty_b, b_present / typed / level_a, level_b, playing, armed
  localparam row_t DIRECTED [N_DIRECTED] = '{
    '{'{KIND_TICK,  1'b1, 17'h00000, 17'h00000, 1'b0}, 1'b1, '{16'd0,     16'd0, 1'b0, 1'b0}},
    '{'{KIND_ROW,   1'b0, 17'h08000, 17'h08000, 1'b1}, 1'b1, '{16'd0,     16'd0, 1'b0, 1'b0}},
    '{'{KIND_END,   1'b0, 17'h00000, 17'h00000, 1'b0}, 1'b1, '{16'd0,     16'd0, 1'b0, 1'b0}},
    '{'{KIND_BEGIN, 1'b0, 17'h00000, 17'h00000, 1'b0}, 1'b1, '{16'd0,     16'd0, 1'b0, 1'b0}},
    // empty load leaves the block unarmed
    '{'{KIND_END,   1'b0, 17'h00000, 17'h00000, 1'b0}, 1'b1, '{16'd0,     16'd0, 1'b0, 1'b0}},
    '{'{KIND_TICK,  1'b1, 17'h00000, 17'h00000, 1'b0}, 1'b1, '{16'd0,     16'd0, 1'b0, 1'b0}},
    '{'{KIND_BEGIN, 1'b0, 17'h00000, 17'h00000, 1'b0}, 1'b1, '{16'd0,     16'd0, 1'b0, 1'b0}},
    '{'{KIND_ROW,   1'b0, 17'h08000, 17'h00000, 1'b1}, 1'b1, '{16'd0,     16'd0, 1'b0, 1'b0}},
    '{'{KIND_ROW,   1'b0, 17'h00000, 17'h08000, 1'b1}, 1'b1, '{16'd0,     16'd0, 1'b0, 1'b0}},
    // negative and just-above-one duties are dropped
    '{'{KIND_ROW,   1'b0, 17'h1FFFF, 17'h08001, 1'b1}, 1'b1, '{16'd0,     16'd0, 1'b0, 1'b0}},
    '{'{KIND_ROW,   1'b0, 17'h10000, 17'h0FFFF, 1'b1}, 1'b1, '{16'd0,     16'd0, 1'b0, 1'b0}},
    // channel b absent
    '{'{KIND_ROW,   1'b0, 17'h04000, 17'h0007B, 1'b0}, 1'b1, '{16'd0,     16'd0, 1'b0, 1'b0}},
    '{'{KIND_ROW,   1'b0, 17'h1FFFF, 17'h1FFFF, 1'b0}, 1'b1, '{16'd0,     16'd0, 1'b0, 1'b0}},
    '{'{KIND_END,   1'b0, 17'h00000, 17'h00000, 1'b0}, 1'b1, '{16'd0,     16'd0, 1'b0, 1'b1}},
    '{'{KIND_TICK,  1'b0, 17'h00000, 17'h00000, 1'b0}, 1'b1, '{16'd0,     16'd0, 1'b0, 1'b1}},
    // start shows step 0 right away
    '{'{KIND_TICK,  1'b1, 17'h00000, 17'h00000, 1'b0}, 1'b1, '{16'd12499, 16'd0, 1'b1, 1'b1}},
    '{'{KIND_TICK,  1'b1, 17'h00000, 17'h00000, 1'b0}, 1'b0, '{16'd0,     16'd0, 1'b0, 1'b0}},
    '{'{KIND_TICK,  1'b1, 17'h00000, 17'h00000, 1'b0}, 1'b0, '{16'd0,     16'd0, 1'b0, 1'b0}},
    '{'{KIND_TICK,  1'b1, 17'h00000, 17'h00000, 1'b0}, 1'b0, '{16'd0,     16'd0, 1'b0, 1'b0}},
    '{'{KIND_TICK,  1'b0, 17'h00000, 17'h00000, 1'b0}, 1'b1, '{16'd0,     16'd0, 1'b0, 1'b1}},
    '{'{KIND_TICK,  1'b1, 17'h00000, 17'h00000, 1'b0}, 1'b1, '{16'd12499, 16'd0, 1'b1, 1'b1}},
    '{'{KIND_ROW,   1'b1, 17'h00000, 17'h00000, 1'b1}, 1'b0, '{16'd0,     16'd0, 1'b0, 1'b0}},
    // begin load while playing, then a restarted load
    '{'{KIND_BEGIN, 1'b0, 17'h00000, 17'h00000, 1'b0}, 1'b1, '{16'd0,     16'd0, 1'b0, 1'b0}},
    '{'{KIND_BEGIN, 1'b0, 17'h00000, 17'h00000, 1'b0}, 1'b1, '{16'd0,     16'd0, 1'b0, 1'b0}},
    '{'{KIND_ROW,   1'b0, 17'h1FFFF, 17'h08000, 1'b1}, 1'b1, '{16'd0,     16'd0, 1'b0, 1'b0}},
    '{'{KIND_END,   1'b0, 17'h00000, 17'h00000, 1'b0}, 1'b1, '{16'd0,     16'd0, 1'b0, 1'b1}},
    // empty channel a reads zero
    '{'{KIND_TICK,  1'b1, 17'h00000, 17'h00000, 1'b0}, 1'b1, '{16'd0, 16'd12499, 1'b1, 1'b1}},
    '{'{KIND_TICK,  1'b1, 17'h00000, 17'h00000, 1'b0}, 1'b0, '{16'd0,     16'd0, 1'b0, 1'b0}}
  };

  localparam logic [CFG_W-1:0] PHASE_STEP [N_PHASES] = '{
    16'd1, 16'd0, 16'd2, 16'd65535, 16'd3, 16'd1
  };
  localparam logic [CFG_W-1:0] PHASE_WRAP [N_PHASES] = '{
    16'd12499, 16'd0, 16'd65535, 16'd1, 16'd4000, 16'd32768
  };

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  tdps_in_if  in_ch ();
  tdps_out_if out_ch ();

  two_channel_pwm_duty_sequencer_core #(
    .MAX_STEPS (STEPS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // sequencer shadow state
  logic [DUTY_W-1:0] tab_a [STEPS];
  logic [DUTY_W-1:0] tab_b [STEPS];
  int unsigned       len_a;
  int unsigned       len_b;
  int unsigned       loop_len;
  int unsigned       step_idx;
  int unsigned       ms_cnt;
  bit                loading;
  bit                armed_q;
  bit                running_q;
  logic [CFG_W-1:0]  step_ms_q = STEP_RESET;
  logic [CFG_W-1:0]  wrap_q    = WRAP_RESET;

  levels_t levels_q [$];
  int      err_cnt      = 0;
  int      words_sent   = 0;
  int      src_idle_pct = 25;
  int      snk_idle_pct = 66;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [DUTY_W-1:0] chan_level(input int unsigned len, input bit chan_b);
    int unsigned         idx;
    logic [2*DUTY_W:0]   prod;
    if (!(running_q && armed_q) || len == 0) return '0;
    idx  = (step_idx < len) ? step_idx : len - 1;
    prod = (chan_b ? tab_b[idx] : tab_a[idx]) * wrap_q;
    return prod[15 +: DUTY_W];
  endfunction

  function automatic levels_t step_sequencer(input word_t w);
    int unsigned period;
    levels_t     lv;
    period = (step_ms_q == 0) ? 1 : step_ms_q;
    case (w.kind)
      KIND_TICK: begin
        if (w.trigger && !running_q && armed_q) begin
          running_q = 1'b1;
          step_idx  = 0;
          ms_cnt    = 0;
        end else if (!w.trigger && running_q) begin
          running_q = 1'b0;
        end else if (running_q && armed_q) begin
          ms_cnt++;
          // >= covers a step_ms lowered below the running count
          if (ms_cnt >= period) begin
            ms_cnt = 0;
            step_idx++;
            if (step_idx >= loop_len) step_idx = 0;
          end
        end
      end
      KIND_BEGIN: begin
        len_a     = 0;
        len_b     = 0;
        loading   = 1'b1;
        armed_q   = 1'b0;
        running_q = 1'b0;
      end
      KIND_ROW: begin
        if (loading) begin
          if (len_a < STEPS && w.duty_a <= DUTY_ONE) begin
            tab_a[len_a] = w.duty_a[DUTY_W-1:0];
            len_a++;
          end
          if (w.b_present && len_b < STEPS && w.duty_b <= DUTY_ONE) begin
            tab_b[len_b] = w.duty_b[DUTY_W-1:0];
            len_b++;
          end
        end
      end
      KIND_END: begin
        if (loading) begin
          loading  = 1'b0;
          loop_len = (len_a > len_b) ? len_a : len_b;
          armed_q  = loop_len > 0;
          step_idx = 0;
          ms_cnt   = 0;
        end
      end
    endcase
    lv.level_a = chan_level(len_a, 1'b0);
    lv.level_b = chan_level(len_b, 1'b1);
    lv.playing = running_q && armed_q;
    lv.armed   = armed_q;
    return lv;
  endfunction

  function automatic word_t mk_word(input kind_t k, input logic trig,
                                    input logic [IN_DUTY_W-1:0] da,
                                    input logic [IN_DUTY_W-1:0] db, input logic bp);
    word_t w;
    w.kind      = k;
    w.trigger   = trig;
    w.duty_a    = da;
    w.duty_b    = db;
    w.b_present = bp;
    return w;
  endfunction

  function automatic logic [IN_DUTY_W-1:0] rand_duty();
    case ($urandom_range(11))
      0:       return DUTY_ONE;
      1:       return '0;
      2:       return IN_DUTY_W'($urandom);  // any pattern, about half negative
      3:       return IN_DUTY_W'($urandom_range(65535, 32769));
      default: return IN_DUTY_W'($urandom_range(32768));
    endcase
  endfunction

  task automatic send_word(input word_t w, input bit typed, input levels_t want);
    levels_t lv;
    if ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_ch.valid     <= 1'b1;
    in_ch.kind      <= w.kind;
    in_ch.trigger   <= w.trigger;
    in_ch.duty_a    <= w.duty_a;
    in_ch.duty_b    <= w.duty_b;
    in_ch.b_present <= w.b_present;
    do @(posedge clk); while (!in_ch.ready);
    lv = step_sequencer(w);
    levels_q.push_back(typed ? want : lv);
    words_sent++;
  endtask

  task automatic program_regs(input logic [CFG_W-1:0] step_val,
                              input logic [CFG_W-1:0] wrap_val);
    in_ch.valid <= 1'b0;
    while (levels_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_STEP_MS;
    cfg_wdata <= step_val;
    @(posedge clk);
    cfg_idx   <= REG_PWM_WRAP;
    cfg_wdata <= wrap_val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    step_ms_q = step_val;
    wrap_q    = wrap_val;
  endtask

  // mostly load-then-play sequences with random content, plus noise bursts
  task automatic run_phase(input int target);
    int stop_at;
    int n_rows;
    stop_at = words_sent + target;
    while (words_sent < stop_at) begin
      if ($urandom_range(9) < 8) begin
        send_word(mk_word(KIND_BEGIN, 1'($urandom), '0, '0, 1'b0), 1'b0, '0);
        case ($urandom_range(9))
          0:       n_rows = 0;
          1:       n_rows = $urandom_range(STEPS + 6, STEPS - 4);  // runs into a full table
          default: n_rows = $urandom_range(8, 1);
        endcase
        repeat (n_rows)
          send_word(mk_word(KIND_ROW, 1'($urandom), rand_duty(), rand_duty(),
                            $urandom_range(3) != 0), 1'b0, '0);
        send_word(mk_word(KIND_END, 1'($urandom), rand_duty(), rand_duty(), 1'($urandom)),
                  1'b0, '0);
        repeat ($urandom_range(40, 4))
          send_word(mk_word(KIND_TICK, $urandom_range(11) != 0, IN_DUTY_W'($urandom),
                            IN_DUTY_W'($urandom), 1'($urandom)), 1'b0, '0);
      end else begin
        repeat ($urandom_range(5, 1))
          send_word(mk_word(kind_t'($urandom_range(3)), 1'($urandom), IN_DUTY_W'($urandom),
                            IN_DUTY_W'($urandom), 1'($urandom)), 1'b0, '0);
      end
    end
  endtask

  always @(posedge clk) out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);

  always @(posedge clk) begin : check_levels
    levels_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (levels_q.size() == 0) begin
        $error("result word with no expectation pending");
        err_cnt++;
      end else begin
        want = levels_q.pop_front();
        if (out_ch.level_a !== want.level_a) begin
          $error("level_a: expected %0d, got %0d", want.level_a, out_ch.level_a);
          err_cnt++;
        end
        if (out_ch.level_b !== want.level_b) begin
          $error("level_b: expected %0d, got %0d", want.level_b, out_ch.level_b);
          err_cnt++;
        end
        if (out_ch.playing !== want.playing) begin
          $error("playing: expected %0b, got %0b", want.playing, out_ch.playing);
          err_cnt++;
        end
        if (out_ch.armed !== want.armed) begin
          $error("armed: expected %0b, got %0b", want.armed, out_ch.armed);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_idx         <= REG_STEP_MS;
    cfg_wdata       <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.kind      <= KIND_TICK;
    in_ch.trigger   <= 1'b0;
    in_ch.duty_a    <= '0;
    in_ch.duty_b    <= '0;
    in_ch.b_present <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++)
      send_word(DIRECTED[i].w, DIRECTED[i].typed, DIRECTED[i].want);

    for (int p = 0; p < N_PHASES; p++) begin
      case (p / 2)
        0: begin src_idle_pct = 25; snk_idle_pct = 66; end
        1: begin src_idle_pct = 66; snk_idle_pct = 25; end
        default: begin src_idle_pct = 0; snk_idle_pct = 0; end
      endcase
      program_regs(PHASE_STEP[p],
                   (p == 4) ? CFG_W'($urandom_range(65534, 2)) : PHASE_WRAP[p]);
      run_phase(285);
    end

    in_ch.valid <= 1'b0;
    while (levels_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[files.f]
rtl/tdps_pkg.sv
rtl/tdps_if.sv
rtl/tdps_ram.sv
rtl/tdps_ctrl.sv
rtl/tdps_level.sv
rtl/two_channel_pwm_duty_sequencer_core.sv
dv/two_channel_pwm_duty_sequencer_core_tb.sv
